// ===== design/npds_pkg.sv =====
`default_nettype none

package npds_pkg;

    localparam int MAX_POINTS = 65536;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int RADIUS_W = 24;
    localparam int EXIT_W   = 48;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 1;

    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
    localparam int REM_W      = SQRT_STEPS + 2;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT   = 1'd1;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic [RADIUS_W-1:0] distance;
        logic                map_empty;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic clear;
        logic append;
        logic capture;
        logic scan_start;
        logic sqrt_start;
        logic out_load;
        logic out_empty;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic sqrt_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/npds_sqrt.sv =====
`default_nettype none

module npds_sqrt
    import npds_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SQ_W-1:0]     i_value,
    output logic                     o_done,
    output logic [SQRT_STEPS-1:0]    o_root
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [SQRT_CNT_W-1:0] r_cnt, n_cnt;
    logic [SQ_W-1:0]       r_val, n_val;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [SQRT_STEPS-1:0] r_root, n_root;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    // one result bit per step, restoring form
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_val[SQ_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = SQRT_CNT_W'(SQRT_STEPS - 1);
            n_val  = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_val = {r_val[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[SQRT_STEPS-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[SQRT_STEPS-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - SQRT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== design/npds_dp.sv =====
`default_nettype none

module npds_dp
    import npds_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_st,
    input  wire t_in_item             i_item,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data
);

    logic [RADIUS_W-1:0] r_radius;
    logic [EXIT_W-1:0]   r_exit;
    logic [CNT_W-1:0]    r_count;
    t_point              r_mem [MAX_POINTS];
    t_point              r_q;
    t_point              r_rd;

    logic                r_issuing;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_v1, r_v2, r_v3, r_v4;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]     r_sx, r_sy, r_sz;
    logic [SUM_W-1:0]    r_d;
    logic [SQ_W-1:0]     r_min;
    logic                r_hit;

    logic                r_out_valid;
    t_out_item           r_out;

    logic                full;
    logic                last_issue;
    logic signed [2*DIFF_W-1:0] px, py, pz;
    logic                d_lt_min, d_lt_exit, min_lt_exit;
    logic                sqrt_done;
    logic [SQRT_STEPS-1:0] root;
    logic [RADIUS_W-1:0] capped;
    t_point              new_pt;

    assign full       = (r_count == CNT_W'(MAX_POINTS));
    assign last_issue = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign new_pt     = '{x: i_item.coord_x, y: i_item.coord_y, z: i_item.coord_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_W'(1024);
            r_exit   <= EXIT_W'(105);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_EXIT:   r_exit   <= i_cfg_data[EXIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // point store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_mem[r_count[ADDR_W-1:0]] <= new_pt;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q <= new_pt;
        end
    end

    // scan issue and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_idx     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_issuing <= 1'b1;
            r_idx     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_v1 <= r_issuing && !r_hit;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_issuing) begin
                r_idx <= r_idx + ADDR_W'(1);
                if (last_issue || r_hit) begin
                    r_issuing <= 1'b0;
                end
            end
            if (r_v4 && !r_hit) begin
                r_hit <= d_lt_min ? d_lt_exit : min_lt_exit;
            end
        end
    end

    assign px = r_dx * r_dx;
    assign py = r_dy * r_dy;
    assign pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_dx <= DIFF_W'(r_q.x) - DIFF_W'(r_rd.x);
        r_dy <= DIFF_W'(r_q.y) - DIFF_W'(r_rd.y);
        r_dz <= DIFF_W'(r_q.z) - DIFF_W'(r_rd.z);
        r_sx <= px[SQ_W-1:0];
        r_sy <= py[SQ_W-1:0];
        r_sz <= pz[SQ_W-1:0];
        r_d  <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
    end

    assign d_lt_min    = (r_d < SUM_W'(r_min));
    assign d_lt_exit   = (r_d < SUM_W'(r_exit));
    assign min_lt_exit = (r_min < r_exit);

    // running minimum starts at radius squared, frozen once the exit test fires
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_min <= SQ_W'(r_radius * r_radius);
        end else if (r_v4 && !r_hit && d_lt_min) begin
            r_min <= r_d[SQ_W-1:0];
        end
    end

    npds_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_min),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign capped = (RADIUS_W'(root) > r_radius) ? r_radius : RADIUS_W'(root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.distance  <= i_cmd.out_empty ? r_radius : capped;
            r_out.map_empty <= i_cmd.out_empty;
        end
    end

    assign o_st.count_zero = (r_count == '0);
    assign o_st.scan_done  = r_hit || !(r_issuing || r_v1 || r_v2 || r_v3 || r_v4);
    assign o_st.sqrt_done  = sqrt_done;
    assign o_st.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/npds_ctrl.sv =====
`default_nettype none

module npds_ctrl
    import npds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_op,
    output logic            o_in_ready,
    input  wire t_status    i_st,
    output t_cmd            o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_empty, n_empty;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_empty = r_empty;
        o_cmd   = '0;
        o_cmd.out_empty = r_empty;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_CLEAR:  o_cmd.clear = 1'b1;
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_QUERY: begin
                            o_cmd.capture = 1'b1;
                            if (i_st.count_zero) begin
                                n_empty = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_empty = 1'b0;
                                o_cmd.scan_start = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_st.scan_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_st.sqrt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_empty <= n_empty;
        end
    end

endmodule

`default_nettype wire

// ===== design/nearest_point_distance_search.sv =====
// Brute-force nearest point search over a store of up to MAX_POINTS 3D points
// (signed 1/1024 m coordinates). A clear or an append item completes without
// leaving the idle state; an append to a full store is dropped. A query streams
// the stored points in order through a distance pipeline fed by the point
// memory's single read port, one point per cycle, stopping early when the
// running minimum falls below early_exit_square, and then runs a 24 step
// bit-serial square root. A query on an empty store answers with the radius
// and map_empty set. One item is in work at a time; the result sits in an
// output register until taken.
// Write configuration only while no query is in flight.
`default_nettype none

module nearest_point_distance_search
    import npds_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    npds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.operation),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    npds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_item      (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
